// ===== hdl/assert_macros.svh =====
// Assertion macros shared by the triangle face normal RTL.
// Every check is clocked on clock and is switched off while reset is high.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain property, which is checked at every rising clock edge.
`define TFN_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define TFN_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hdl/tfn_pkg.sv =====
// Package for the triangle face normal core: widths, payload structs and sequencer states.
// It depends on nothing; every module of the block imports it.
package tfn_pkg;

   localparam int COORD_BITS = 16;
   localparam int EDGE_DROP  = (COORD_BITS > 20) ? (COORD_BITS - 20) : 0;
   localparam int EDGE_W     = COORD_BITS + 1 - EDGE_DROP;
   localparam int CROSS_W    = 2 * EDGE_W + 1;
   localparam int MAG_W      = (CROSS_W > 31) ? CROSS_W : 31;
   localparam int MUL_W      = 32;
   localparam int NORM_HI    = 30;
   localparam int NORM_LO    = 29;
   localparam int MAG_OP_W   = 30;
   localparam int SUM_W      = 62;
   localparam int ROOT_W     = 31;
   localparam int ROOT_STEPS = 31;
   localparam int ROOT_CNT_W = 5;
   localparam int NORM_FRAC  = 14;
   localparam int NUM_W      = MAG_OP_W + NORM_FRAC + 1;
   localparam int QUOT_W     = NORM_FRAC + 1;
   localparam int DIV_CNT_W  = 4;
   localparam int NORM_W     = 16;
   localparam int CORNERS    = 3;

   typedef struct packed {
      logic signed [COORD_BITS-1:0] pos_x;
      logic signed [COORD_BITS-1:0] pos_y;
      logic signed [COORD_BITS-1:0] pos_z;
   } vertex_type;

   typedef struct packed {
      logic signed [NORM_W-1:0] norm_x;
      logic signed [NORM_W-1:0] norm_y;
      logic signed [NORM_W-1:0] norm_z;
      logic                     degenerate;
      logic                     last_copy;
   } normal_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_CROSS,
      ST_ABS,
      ST_MAX,
      ST_NORM,
      ST_SQ,
      ST_ROOT_GO,
      ST_ROOT_WAIT,
      ST_DIV_GO,
      ST_DIV_WAIT,
      ST_EMIT
   } tfn_state_type;

endpackage

// ===== hdl/tfn_mul.sv =====
// Shared signed multiplier of the face normal core, with its product registered.
// Uses tfn_pkg for the operand width.
module tfn_mul import tfn_pkg::*; (
   input  logic                        clock,
   input  logic signed [MUL_W-1:0]     mul_a,
   input  logic signed [MUL_W-1:0]     mul_b,
   output logic signed [2*MUL_W-1:0]   mul_prod
);

   logic signed [2*MUL_W-1:0] prod_ff;
   logic signed [2*MUL_W-1:0] prod_in;

   assign prod_in  = mul_a * mul_b;
   assign mul_prod = prod_ff;

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

endmodule

// ===== hdl/tfn_isqrt.sv =====
// Bit-pair integer square root for the face normal core, one step per cycle.
// Uses tfn_pkg for widths and the step count; done pulses for one cycle at the end.
module tfn_isqrt import tfn_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              root_start,
   input  logic [SUM_W-1:0]  radicand,
   output logic              root_done,
   output logic [ROOT_W-1:0] root
);

   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [ROOT_CNT_W-1:0] count_ff, count_in;
   logic [SUM_W-1:0]      rest_ff, rest_in;
   logic [SUM_W-1:0]      res_ff, res_in;
   logic [SUM_W-1:0]      one_hot;
   logic [SUM_W-1:0]      trial;

   // The trial bit walks down by a factor of four each step.
   assign one_hot = SUM_W'(1) << {count_ff, 1'b0};
   assign trial   = res_ff + one_hot;

   always_comb begin
      busy_in  = busy_ff;
      done_in  = 1'b0;
      count_in = count_ff;
      rest_in  = rest_ff;
      res_in   = res_ff;
      if (root_start) begin
         busy_in  = 1'b1;
         count_in = ROOT_CNT_W'(ROOT_STEPS - 1);
         rest_in  = radicand;
         res_in   = '0;
      end else if (busy_ff) begin
         if (rest_ff >= trial) begin
            rest_in = rest_ff - trial;
            res_in  = (res_ff >> 1) + one_hot;
         end else begin
            res_in = res_ff >> 1;
         end
         count_in = count_ff - 1'b1;
         if (count_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      count_ff <= count_in;
      rest_ff  <= rest_in;
      res_ff   <= res_in;
   end

   assign root_done = done_ff;
   assign root      = res_ff[ROOT_W-1:0];

endmodule

// ===== hdl/tfn_div.sv =====
// Restoring divider for one normal component: (mag * 2^14 + root / 2) / root.
// Uses tfn_pkg; one quotient bit per cycle, done pulses for one cycle at the end.
module tfn_div import tfn_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                div_start,
   input  logic [MAG_OP_W-1:0] div_mag,
   input  logic [ROOT_W-1:0]   div_root,
   output logic                div_done,
   output logic [QUOT_W-1:0]   quot
);

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [DIV_CNT_W-1:0] count_ff, count_in;
   logic [NUM_W-1:0]     rem_ff, rem_in;
   logic [ROOT_W-1:0]    dvsr_ff, dvsr_in;
   logic [QUOT_W-1:0]    quot_ff, quot_in;
   logic [NUM_W-1:0]     numer;
   logic [NUM_W-1:0]     trial;
   logic                 take;

   // The rounded quotient never exceeds 2^14, so fifteen bits are enough.
   assign numer = {1'b0, div_mag, NORM_FRAC'(0)} + NUM_W'(div_root >> 1);
   assign trial = NUM_W'(dvsr_ff) << count_ff;
   assign take  = rem_ff >= trial;

   always_comb begin
      busy_in  = busy_ff;
      done_in  = 1'b0;
      count_in = count_ff;
      rem_in   = rem_ff;
      dvsr_in  = dvsr_ff;
      quot_in  = quot_ff;
      if (div_start) begin
         busy_in  = 1'b1;
         count_in = DIV_CNT_W'(QUOT_W - 1);
         rem_in   = numer;
         dvsr_in  = div_root;
         quot_in  = '0;
      end else if (busy_ff) begin
         if (take) begin
            rem_in = rem_ff - trial;
         end
         quot_in  = {quot_ff[QUOT_W-2:0], take};
         count_in = count_ff - 1'b1;
         if (count_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      count_ff <= count_in;
      rem_ff   <= rem_in;
      dvsr_ff  <= dvsr_in;
      quot_ff  <= quot_in;
   end

   assign div_done = done_ff;
   assign quot     = quot_ff;

endmodule

// ===== hdl/triangle_face_normal_core.sv =====
// Top level of the triangle face normal core: sequencer, vertex store and result register.
// Uses tfn_pkg, tfn_mul, tfn_isqrt, tfn_div and the macros of assert_macros.svh.
//
// Usage. Vertices arrive on the req_ channel (valid/ready), three to a triangle, as
// signed Q4.12 x, y, z. The first two vertices of a triangle are stored and give no
// result. The third starts the normal computation: six products on the shared
// multiplier, magnitude and maximum, a one-bit-a-cycle scaling shift, three squares,
// a 31-step square root and three 15-step divisions. A zero cross product skips the
// scaling shift, the squares, the root and the divisions. While the normal is being
// computed req_ready is low, so a triangle occupies the block for the computation
// plus its three result transfers.
// The rsp_ channel then shows the same unit normal (signed Q1.14) three times, the
// third marked last_copy; a zero cross product gives zeros with degenerate set.
// While the results wait for rsp_ready, the first two vertices of the next triangle
// may still be transferred; its third vertex waits until the last copy has gone.
// A synchronous reset empties the triangle in progress and drops any waiting result.
`include "assert_macros.svh"

module triangle_face_normal_core import tfn_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  vertex_type req_data,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output normal_type rsp_data
);

   tfn_state_type state_ff, state_in;
   logic [2:0]    step_ff, step_in;
   logic [1:0]    copy_ff, copy_in;
   logic [1:0]    corner_ff, corner_in;

   vertex_type    vert0_ff, vert1_ff, vert2_ff;
   logic signed [CROSS_W-1:0] acc_ff;
   logic signed [CROSS_W-1:0] cross_ff [CORNERS];
   logic [MAG_W-1:0]          mag_ff [CORNERS];
   logic                      neg_ff [CORNERS];
   logic [MAG_W-1:0]          max_ff;
   logic [SUM_W-1:0]          sum_ff;
   logic signed [NORM_W-1:0]  norm_ff [CORNERS];
   logic                      degen_ff;

   logic req_xfer, rsp_xfer;
   logic signed [EDGE_W-1:0]  e1x, e1y, e1z, e2x, e2y, e2z;
   logic signed [MUL_W-1:0]   mul_a, mul_b;
   logic signed [2*MUL_W-1:0] mul_prod;
   logic signed [CROSS_W-1:0] prod_lo;
   logic [1:0]                cross_idx;
   logic [1:0]                comp_idx;
   logic [MAG_W-1:0]          mag_next [CORNERS];
   logic [MAG_W-1:0]          max01, max_all;
   logic                      too_big, too_small;
   logic                      root_start, root_done;
   logic [ROOT_W-1:0]         root;
   logic                      div_start, div_done;
   logic [MAG_OP_W-1:0]       div_mag;
   logic [QUOT_W-1:0]         quot;
   logic [NORM_W-1:0]         quot_ext;
   logic                      third_xfer, last_xfer;
   logic                      norm_zero, norm_in_range;

   // Floor-shifted difference of two coordinates.
   function automatic logic signed [EDGE_W-1:0] edge_diff(
      input logic signed [COORD_BITS-1:0] a,
      input logic signed [COORD_BITS-1:0] b);
      logic [COORD_BITS:0] diff;
      diff = {a[COORD_BITS-1], a} - {b[COORD_BITS-1], b};
      return $signed(diff[COORD_BITS:EDGE_DROP]);
   endfunction

   // True when a Q1.14 component lies within plus or minus one.
   function automatic logic in_unit(input logic signed [NORM_W-1:0] v);
      return (v <= 16'sd16384) && (v >= -16'sd16384);
   endfunction

   assign req_xfer = req_valid & req_ready;
   assign rsp_xfer = rsp_valid & rsp_ready;

   assign e1x = edge_diff(vert1_ff.pos_x, vert0_ff.pos_x);
   assign e1y = edge_diff(vert1_ff.pos_y, vert0_ff.pos_y);
   assign e1z = edge_diff(vert1_ff.pos_z, vert0_ff.pos_z);
   assign e2x = edge_diff(vert2_ff.pos_x, vert0_ff.pos_x);
   assign e2y = edge_diff(vert2_ff.pos_y, vert0_ff.pos_y);
   assign e2z = edge_diff(vert2_ff.pos_z, vert0_ff.pos_z);

   assign prod_lo   = $signed(mul_prod[CROSS_W-1:0]);
   assign cross_idx = step_ff[2:1] - 2'd1;
   assign comp_idx  = step_ff[1:0];

   always_comb begin
      for (int i = 0; i < CORNERS; i++) begin
         mag_next[i] = cross_ff[i][CROSS_W-1] ? MAG_W'(-MAG_W'(cross_ff[i]))
                                              : MAG_W'(cross_ff[i]);
      end
   end

   assign max01     = (mag_ff[0] > mag_ff[1]) ? mag_ff[0] : mag_ff[1];
   assign max_all   = (max01 > mag_ff[2]) ? max01 : mag_ff[2];
   assign too_big   = |max_ff[MAG_W-1:NORM_HI];
   assign too_small = ~|max_ff[MAG_W-1:NORM_LO];
   assign quot_ext  = NORM_W'(quot);

   // Next state of the sequencer.
   always_comb begin
      state_in  = state_ff;
      step_in   = step_ff;
      copy_in   = copy_ff;
      corner_in = corner_ff;
      if (req_xfer) begin
         case (corner_ff)
            2'd0:    corner_in = 2'd1;
            2'd1:    corner_in = 2'd2;
            2'd2:    corner_in = 2'd0;
            default: corner_in = 2'd1;
         endcase
      end
      case (state_ff)
         ST_IDLE: begin
            if (req_xfer && corner_ff == 2'd2) begin
               state_in = ST_CROSS;
               step_in  = '0;
            end
         end
         ST_CROSS: begin
            if (step_ff == 3'd6) begin
               state_in = ST_ABS;
               step_in  = '0;
            end else begin
               step_in = step_ff + 3'd1;
            end
         end
         ST_ABS:  state_in = ST_MAX;
         ST_MAX:  state_in = ST_NORM;
         ST_NORM: begin
            if (max_ff == '0) begin
               state_in = ST_EMIT;
               copy_in  = '0;
            end else if (!too_big && !too_small) begin
               state_in = ST_SQ;
               step_in  = '0;
            end
         end
         ST_SQ: begin
            if (step_ff == 3'd3) begin
               state_in = ST_ROOT_GO;
            end else begin
               step_in = step_ff + 3'd1;
            end
         end
         ST_ROOT_GO: state_in = ST_ROOT_WAIT;
         ST_ROOT_WAIT: begin
            if (root_done) begin
               state_in = ST_DIV_GO;
               step_in  = '0;
            end
         end
         ST_DIV_GO: state_in = ST_DIV_WAIT;
         ST_DIV_WAIT: begin
            if (div_done) begin
               if (step_ff == 3'd2) begin
                  state_in = ST_EMIT;
                  copy_in  = '0;
               end else begin
                  state_in = ST_DIV_GO;
                  step_in  = step_ff + 3'd1;
               end
            end
         end
         ST_EMIT: begin
            if (rsp_xfer) begin
               if (copy_ff == 2'd2) begin
                  state_in = ST_IDLE;
               end
               copy_in = copy_ff + 2'd1;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Sequencer outputs: handshakes, multiplier operands and unit starts.
   always_comb begin
      req_ready  = 1'b0;
      rsp_valid  = 1'b0;
      mul_a      = '0;
      mul_b      = '0;
      root_start = 1'b0;
      div_start  = 1'b0;
      div_mag    = '0;
      case (state_ff)
         ST_IDLE: req_ready = 1'b1;
         ST_CROSS: begin
            case (step_ff)
               3'd0: begin mul_a = MUL_W'(e1y); mul_b = MUL_W'(e2z); end
               3'd1: begin mul_a = MUL_W'(e1z); mul_b = MUL_W'(e2y); end
               3'd2: begin mul_a = MUL_W'(e1z); mul_b = MUL_W'(e2x); end
               3'd3: begin mul_a = MUL_W'(e1x); mul_b = MUL_W'(e2z); end
               3'd4: begin mul_a = MUL_W'(e1x); mul_b = MUL_W'(e2y); end
               3'd5: begin mul_a = MUL_W'(e1y); mul_b = MUL_W'(e2x); end
               default: begin mul_a = '0; mul_b = '0; end
            endcase
         end
         ST_SQ: begin
            if (step_ff < 3'd3) begin
               mul_a = $signed(MUL_W'(mag_ff[comp_idx][MAG_OP_W-1:0]));
               mul_b = $signed(MUL_W'(mag_ff[comp_idx][MAG_OP_W-1:0]));
            end
         end
         ST_ROOT_GO: root_start = 1'b1;
         ST_DIV_GO: begin
            div_start = 1'b1;
            if (step_ff < 3'd3) begin
               div_mag = mag_ff[comp_idx][MAG_OP_W-1:0];
            end
         end
         ST_EMIT: begin
            rsp_valid = 1'b1;
            req_ready = (corner_ff != 2'd2);
         end
         default: req_ready = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         step_ff   <= '0;
         copy_ff   <= '0;
         corner_ff <= '0;
      end else begin
         state_ff  <= state_in;
         step_ff   <= step_in;
         copy_ff   <= copy_in;
         corner_ff <= corner_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         case (corner_ff)
            2'd0:    vert0_ff <= req_data;
            2'd1:    vert1_ff <= req_data;
            2'd2: begin
               vert2_ff <= req_data;
               degen_ff <= 1'b0;
            end
            default: vert0_ff <= req_data;
         endcase
      end
      case (state_ff)
         ST_CROSS: begin
            // Odd steps bring the first product of a pair, even steps from two on the second.
            if (step_ff[0]) begin
               acc_ff <= prod_lo;
            end else if (step_ff != 3'd0) begin
               cross_ff[cross_idx] <= acc_ff - prod_lo;
            end
         end
         ST_ABS: begin
            for (int i = 0; i < CORNERS; i++) begin
               mag_ff[i] <= mag_next[i];
               neg_ff[i] <= cross_ff[i][CROSS_W-1];
            end
         end
         ST_MAX: max_ff <= max_all;
         ST_NORM: begin
            if (max_ff == '0) begin
               degen_ff <= 1'b1;
               for (int i = 0; i < CORNERS; i++) begin
                  norm_ff[i] <= '0;
               end
            end else if (too_big) begin
               max_ff <= max_ff >> 1;
               for (int i = 0; i < CORNERS; i++) begin
                  mag_ff[i] <= mag_ff[i] >> 1;
               end
            end else if (too_small) begin
               max_ff <= max_ff << 1;
               for (int i = 0; i < CORNERS; i++) begin
                  mag_ff[i] <= mag_ff[i] << 1;
               end
            end
         end
         ST_SQ: begin
            if (step_ff == 3'd1) begin
               sum_ff <= mul_prod[SUM_W-1:0];
            end else if (step_ff != 3'd0) begin
               sum_ff <= sum_ff + mul_prod[SUM_W-1:0];
            end
         end
         ST_DIV_WAIT: begin
            if (div_done && step_ff < 3'd3) begin
               norm_ff[comp_idx] <= neg_ff[comp_idx] ? $signed(-quot_ext)
                                                     : $signed(quot_ext);
            end
         end
         default: ;
      endcase
   end

   tfn_mul u_mul (
      .clock    (clock),
      .mul_a    (mul_a),
      .mul_b    (mul_b),
      .mul_prod (mul_prod)
   );

   tfn_isqrt u_isqrt (
      .clock      (clock),
      .reset      (reset),
      .root_start (root_start),
      .radicand   (sum_ff),
      .root_done  (root_done),
      .root       (root)
   );

   tfn_div u_div (
      .clock     (clock),
      .reset     (reset),
      .div_start (div_start),
      .div_mag   (div_mag),
      .div_root  (root),
      .div_done  (div_done),
      .quot      (quot)
   );

   assign rsp_data.norm_x     = norm_ff[0];
   assign rsp_data.norm_y     = norm_ff[1];
   assign rsp_data.norm_z     = norm_ff[2];
   assign rsp_data.degenerate = degen_ff;
   assign rsp_data.last_copy  = (copy_ff == 2'd2);

   assign third_xfer    = req_xfer && (corner_ff == 2'd2);
   assign last_xfer     = rsp_xfer && rsp_data.last_copy;
   assign norm_zero     = (norm_ff[0] == '0) && (norm_ff[1] == '0) && (norm_ff[2] == '0);
   assign norm_in_range = in_unit(norm_ff[0]) && in_unit(norm_ff[1]) && in_unit(norm_ff[2]);

   `TFN_ASSERT_NEXT(a_third_vertex_stalls, third_xfer, !req_ready, "third vertex did not stall")
   `TFN_ASSERT_NEXT(a_last_copy_ends, last_xfer, !rsp_valid, "result shown after last copy")
   `TFN_ASSERT(a_degen_zero, rsp_valid && degen_ff |-> norm_zero, "degenerate normal not zero")
   `TFN_ASSERT(a_unit_range, rsp_valid |-> norm_in_range, "normal component out of range")

endmodule

// ===== test/triangle_face_normal_core_test.sv =====
// Self-checking testbench for triangle_face_normal_core: vertex stream in, unit face normals out.
// Depends on tfn_pkg for the payload types and widths; the expected normals come from a
// fixed-point predictor kept in this file, or from the directed table where it gives them.
module triangle_face_normal_core_test import tfn_pkg::*; ();

   timeunit 1ns;
   timeprecision 1ps;

   localparam time HALF_PERIOD      = 1ns;
   localparam int  RESET_CYCLES     = 10;
   localparam int  RANDOM_TRIANGLES = 129;
   localparam int  DRAIN_CYCLES     = 250;
   localparam int  CYCLE_LIMIT      = 600000;
   localparam int  DIRECTED_ROWS    = 24;

   localparam longint unsigned SCALE_HIGH = 64'd1 << NORM_HI;
   localparam longint unsigned SCALE_LOW  = 64'd1 << NORM_LO;

   localparam normal_type FLAT_NORMAL = '{16'sd0, 16'sd0, 16'sd0, 1'b1, 1'b0};

   typedef enum int {
      READY_ALWAYS,
      READY_COIN,
      READY_SPARSE,
      READY_PULSE
   } ready_mode_type;

   typedef enum int {
      TRI_SPREAD,
      TRI_TINY,
      TRI_REPEAT,
      TRI_COLLINEAR,
      TRI_EXTREME
   } triangle_kind_type;

   // One line of the directed table. When known is set, want holds the normal of the
   // triangle that this vertex closes, read straight off the arithmetic.
   typedef struct {
      vertex_type vtx;
      logic       known;
      normal_type want;
   } vertex_row_type;

   logic       clock     = 1'b0;
   logic       reset     = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_ready;
   vertex_type req_data  = '0;
   logic       rsp_valid;
   logic       rsp_ready = 1'b0;
   normal_type rsp_data;

   normal_type normal_queue[$];
   vertex_type first_corner  = '0;
   vertex_type second_corner = '0;
   logic [1:0] corners_held  = 2'd0;

   int mismatch_count   = 0;
   int normals_checked  = 0;
   int degenerate_seen  = 0;
   int triangles_sent   = 0;
   int vertices_sent    = 0;
   int burst_left       = 0;
   int cycle_count      = 0;

   ready_mode_type ready_mode = READY_ALWAYS;
   int             mode_left  = 0;
   logic [2:0]     pulse_phase = '0;

   vertex_row_type directed_rows[DIRECTED_ROWS];

   triangle_face_normal_core DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always #(HALF_PERIOD) clock = ~clock;

   // ---------------------------------------------------------------- predictor

   function automatic longint edge_step(input longint to_pt, input longint from_pt);
      longint bias;
      bias = longint'(64'd1 << COORD_BITS);
      return ((to_pt - from_pt + bias) >>> EDGE_DROP)
             - longint'(64'd1 << (COORD_BITS - EDGE_DROP));
   endfunction

   function automatic longint unsigned floor_sqrt(input longint unsigned x);
      longint unsigned acc, probe, rest;
      rest  = x;
      acc   = 0;
      probe = 64'd1 << 62;
      while (probe > rest) probe >>= 2;
      while (probe != 0) begin
         if (rest >= acc + probe) begin
            rest -= acc + probe;
            acc = (acc >> 1) + probe;
         end else begin
            acc >>= 1;
         end
         probe >>= 2;
      end
      return acc;
   endfunction

   function automatic normal_type unit_normal(input vertex_type p0, input vertex_type p1,
                                              input vertex_type p2);
      longint          a[3], b[3], d[3], e1[3], e2[3], c[3];
      longint unsigned mag[3], top, sq_sum, root, q;
      logic            neg[3];
      logic [NORM_W-1:0] comp[3];
      a = '{longint'(p0.pos_x), longint'(p0.pos_y), longint'(p0.pos_z)};
      b = '{longint'(p1.pos_x), longint'(p1.pos_y), longint'(p1.pos_z)};
      d = '{longint'(p2.pos_x), longint'(p2.pos_y), longint'(p2.pos_z)};
      for (int i = 0; i < 3; i++) begin
         e1[i] = edge_step(b[i], a[i]);
         e2[i] = edge_step(d[i], a[i]);
      end
      c[0] = e1[1] * e2[2] - e1[2] * e2[1];
      c[1] = e1[2] * e2[0] - e1[0] * e2[2];
      c[2] = e1[0] * e2[1] - e1[1] * e2[0];
      top = 0;
      for (int i = 0; i < 3; i++) begin
         neg[i] = c[i] < 0;
         mag[i] = neg[i] ? longint'(-c[i]) : longint'(c[i]);
         if (mag[i] > top) top = mag[i];
      end
      if (top == 0) return FLAT_NORMAL;
      // Bring the largest magnitude into [2^29, 2^30); all three move together.
      while (top >= SCALE_HIGH) begin
         top >>= 1;
         for (int i = 0; i < 3; i++) mag[i] >>= 1;
      end
      while (top < SCALE_LOW) begin
         top <<= 1;
         for (int i = 0; i < 3; i++) mag[i] <<= 1;
      end
      sq_sum = mag[0] * mag[0] + mag[1] * mag[1] + mag[2] * mag[2];
      root   = floor_sqrt(sq_sum);
      for (int i = 0; i < 3; i++) begin
         q = ((mag[i] << NORM_FRAC) + (root >> 1)) / root;
         comp[i] = neg[i] ? NORM_W'(-q) : NORM_W'(q);
      end
      return '{comp[0], comp[1], comp[2], 1'b0, 1'b0};
   endfunction

   // Follows the vertex store of the block; a third corner queues three copies of the normal.
   task automatic take_vertex(input vertex_type v, input logic known, input normal_type want);
      normal_type n;
      vertices_sent++;
      if (corners_held == 2'd0) begin
         first_corner = v;
         corners_held = 2'd1;
      end else if (corners_held == 2'd1) begin
         second_corner = v;
         corners_held  = 2'd2;
      end else begin
         corners_held = 2'd0;
         n = known ? want : unit_normal(first_corner, second_corner, v);
         for (int k = 0; k < CORNERS; k++) begin
            n.last_copy = (k == CORNERS - 1);
            normal_queue.insert(normal_queue.size(), n);
         end
         triangles_sent++;
      end
   endtask

   // ---------------------------------------------------------------- checking

   task automatic report_mismatch(input string what);
      mismatch_count++;
      $display("[%0t] mismatch: %s", $realtime, what);
   endtask

   task automatic check_normal(input normal_type got);
      normal_type want;
      if (normal_queue.size() == 0) begin
         report_mismatch($sformatf("normal %0d/%0d/%0d with none expected",
                                   got.norm_x, got.norm_y, got.norm_z));
         return;
      end
      want = normal_queue.pop_front();
      normals_checked++;
      if (got.norm_x !== want.norm_x)
         report_mismatch($sformatf("norm_x %0d, expected %0d", got.norm_x, want.norm_x));
      if (got.norm_y !== want.norm_y)
         report_mismatch($sformatf("norm_y %0d, expected %0d", got.norm_y, want.norm_y));
      if (got.norm_z !== want.norm_z)
         report_mismatch($sformatf("norm_z %0d, expected %0d", got.norm_z, want.norm_z));
      if (got.degenerate !== want.degenerate)
         report_mismatch($sformatf("degenerate %b, expected %b", got.degenerate,
                                   want.degenerate));
      if (got.last_copy !== want.last_copy)
         report_mismatch($sformatf("last_copy %b, expected %b", got.last_copy,
                                   want.last_copy));
      if (want.degenerate && want.last_copy) degenerate_seen++;
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) check_normal(rsp_data);
   end

   // The receiver picks a new stall habit at random whenever its current one runs out.
   always @(posedge clock) begin
      pulse_phase <= pulse_phase + 3'd1;
      if (mode_left == 0) begin
         ready_mode <= ready_mode_type'($urandom_range(READY_ALWAYS, READY_PULSE));
         mode_left  <= $urandom_range(20, 300);
      end else begin
         mode_left <= mode_left - 1;
      end
      case (ready_mode)
         READY_ALWAYS: rsp_ready <= 1'b1;
         READY_COIN:   rsp_ready <= 1'($urandom_range(0, 1));
         READY_SPARSE: rsp_ready <= ($urandom_range(0, 7) == 0);
         READY_PULSE:  rsp_ready <= (pulse_phase == 3'd0);
         default:      rsp_ready <= 1'b1;
      endcase
   end

   // ---------------------------------------------------------------- stimulus

   function automatic vertex_type vtx(input int x, input int y, input int z);
      return '{COORD_BITS'(x), COORD_BITS'(y), COORD_BITS'(z)};
   endfunction

   function automatic vertex_row_type row(input int x, input int y, input int z);
      return '{vtx(x, y, z), 1'b0, FLAT_NORMAL};
   endfunction

   function automatic vertex_row_type row_known(input int x, input int y, input int z,
                                                input int nx, input int ny, input int nz,
                                                input logic flat);
      return '{vtx(x, y, z), 1'b1, '{NORM_W'(nx), NORM_W'(ny), NORM_W'(nz), flat, 1'b0}};
   endfunction

   function automatic int clamp_coord(input int v);
      int hi, lo;
      hi = (1 << (COORD_BITS - 1)) - 1;
      lo = -(1 << (COORD_BITS - 1));
      return (v > hi) ? hi : ((v < lo) ? lo : v);
   endfunction

   function automatic vertex_type rand_vertex();
      return vertex_type'($urandom_range(0, 65535) | (48'($urandom()) << 16));
   endfunction

   function automatic int rand_offset(input int span);
      return int'($urandom_range(0, 2 * span)) - span;
   endfunction

   function automatic vertex_type shifted(input vertex_type base, input int dx, input int dy,
                                          input int dz);
      return vtx(clamp_coord(int'(base.pos_x) + dx), clamp_coord(int'(base.pos_y) + dy),
                 clamp_coord(int'(base.pos_z) + dz));
   endfunction

   function automatic int edge_value();
      int picks[7];
      picks = '{-32768, -32767, -1, 0, 1, 32766, 32767};
      return picks[$urandom_range(0, 6)];
   endfunction

   task automatic make_triangle(output vertex_type corner[3]);
      triangle_kind_type kind;
      int sel, dx, dy, dz, k;
      sel = $urandom_range(0, 9);
      kind = (sel < 6) ? TRI_SPREAD : triangle_kind_type'(sel - 5);
      corner[0] = rand_vertex();
      corner[1] = rand_vertex();
      corner[2] = rand_vertex();
      case (kind)
         TRI_TINY: begin
            corner[1] = shifted(corner[0], rand_offset(8), rand_offset(8), rand_offset(8));
            corner[2] = shifted(corner[0], rand_offset(8), rand_offset(8), rand_offset(8));
         end
         TRI_REPEAT: begin
            case ($urandom_range(0, 2))
               0:       corner[1] = corner[0];
               1:       corner[2] = corner[0];
               default: corner[2] = corner[1];
            endcase
         end
         TRI_COLLINEAR: begin
            dx = rand_offset(2000);
            dy = rand_offset(2000);
            dz = rand_offset(2000);
            k  = rand_offset(3);
            corner[0] = vtx(rand_offset(20000), rand_offset(20000), rand_offset(20000));
            corner[1] = shifted(corner[0], dx, dy, dz);
            corner[2] = shifted(corner[0], k * dx, k * dy, k * dz);
         end
         TRI_EXTREME: begin
            for (int i = 0; i < 3; i++) corner[i] = vtx(edge_value(), edge_value(), edge_value());
         end
         default: ;
      endcase
   endtask

   // Sends one vertex inside the current burst, opening a new burst after a gap if needed.
   task automatic send_vertex(input vertex_type v, input logic known, input normal_type want);
      int gap;
      if (burst_left == 0) begin
         gap        = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 150) : $urandom_range(0, 3);
         burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 8);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      req_valid <= 1'b1;
      req_data  <= v;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      take_vertex(v, known, want);
      burst_left--;
   endtask

   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("timeout after %0d cycles, %0d normals still expected", cycle_count,
               normal_queue.size());
      $display("end of test: mismatches");
      $finish;
   end

   initial begin
      vertex_type corner[3];
      // Unit steps are 4096 in Q4.12; the typed normals are exact axis vectors or zero.
      directed_rows = '{
         row(0, 0, 0), row(4096, 0, 0), row_known(0, 4096, 0, 0, 0, 16384, 1'b0),
         row(0, 0, 0), row(0, 0, 0), row_known(0, 0, 0, 0, 0, 0, 1'b1),
         row(-32768, -32768, -32768), row(32767, 32767, 32767),
         row_known(0, 0, 0, 0, 0, 0, 1'b1),
         row(0, 0, 0), row(0, 4096, 0), row_known(4096, 0, 0, 0, 0, -16384, 1'b0),
         row(0, 0, 0), row(0, 1, 0), row_known(0, 0, 1, 16384, 0, 0, 1'b0),
         row(0, 0, 0), row(0, 0, 4096), row_known(4096, 0, 0, 0, 16384, 0, 1'b0),
         row(-32768, -32768, -32768), row(32767, -32768, -32768), row(-32768, 32767, -32768),
         row(32767, 32767, 32767), row(-32768, 32767, -32768), row(32767, -32768, -32768)
      };
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i])
         send_vertex(directed_rows[i].vtx, directed_rows[i].known, directed_rows[i].want);

      for (int t = 0; t < RANDOM_TRIANGLES; t++) begin
         make_triangle(corner);
         for (int i = 0; i < 3; i++) send_vertex(corner[i], 1'b0, FLAT_NORMAL);
      end
      req_valid <= 1'b0;

      while (normal_queue.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("sent %0d vertices forming %0d triangles under random gaps and stalls",
               vertices_sent, triangles_sent);
      $display("checked %0d normal transfers, %0d triangles degenerate", normals_checked,
               degenerate_seen);
      if (mismatch_count == 0 && normal_queue.size() == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
+incdir+hdl
hdl/tfn_pkg.sv
hdl/tfn_mul.sv
hdl/tfn_isqrt.sv
hdl/tfn_div.sv
hdl/triangle_face_normal_core.sv
test/triangle_face_normal_core_test.sv
